// ----- design/assert_macros.svh -----
// Assertion macros shared by the scheduler modules.
// Each macro expects signals named clk and arst_n in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("scheduler assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("scheduler assertion failed");

`endif

// ----- design/pts_pkg.sv -----
package pts_pkg;

	localparam int PTS_MAX_TASKS = 16;
	localparam int PTS_IN_DATA_W = 48;
	localparam int PTS_OUT_DATA_W = 48;
	localparam int PTS_CMD_W = 3;

	typedef enum logic [2:0] {
		CMD_TICK = 3'd0,
		CMD_SCHED = 3'd1,
		CMD_ADD = 3'd2,
		CMD_SLEEP = 3'd3,
		CMD_LAUNCH = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		TS_READY = 2'd0,
		TS_RUNNING = 2'd1,
		TS_SLEEPING = 2'd2
	} task_st_t;

	typedef struct packed {
		logic cmd_load;
		logic exec;
		logic cur_rd;
		logic scan_rd;
		logic demote;
		logic pick;
		logic out_load;
	} pts_ctrl_t;

	typedef struct packed {
		logic [2:0] cmd;
		logic cnt_zero;
		logic scan_last;
		logic out_free;
	} pts_stat_t;

endpackage

// ----- design/pts_ctrl.sv -----
`include "assert_macros.svh"

module pts_ctrl
	import pts_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input pts_stat_t stat,
	output pts_ctrl_t ctrl
);

	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_EXEC = 8'b0000_0010,
		ST_CUR = 8'b0000_0100,
		ST_SCAN = 8'b0000_1000,
		ST_LAST = 8'b0001_0000,
		ST_DEMOTE = 8'b0010_0000,
		ST_PICK = 8'b0100_0000,
		ST_OUT = 8'b1000_0000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic accept;

	assign s_tready = (state_q == ST_IDLE);
	assign accept = s_tvalid && s_tready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				case (stat.cmd)
					CMD_TICK: state_d = stat.cnt_zero ? ST_OUT : ST_SCAN;
					CMD_SCHED: state_d = stat.cnt_zero ? ST_OUT : ST_CUR;
					default: state_d = ST_OUT;
				endcase
			end
			ST_CUR: state_d = ST_SCAN;
			ST_SCAN: begin
				if (stat.scan_last) begin
					state_d = ST_LAST;
				end
			end
			ST_LAST: state_d = (stat.cmd == CMD_SCHED) ? ST_DEMOTE : ST_OUT;
			ST_DEMOTE: state_d = ST_PICK;
			ST_PICK: state_d = ST_OUT;
			ST_OUT: begin
				if (stat.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		ctrl.cmd_load = accept;
		ctrl.exec = (state_q == ST_EXEC);
		ctrl.cur_rd = (state_q == ST_CUR);
		ctrl.scan_rd = (state_q == ST_SCAN);
		ctrl.demote = (state_q == ST_DEMOTE);
		ctrl.pick = (state_q == ST_PICK);
		ctrl.out_load = (state_q == ST_OUT) && stat.out_free;
	end

	`ASSERT_NEXT(a_accept_exec, accept, state_q == ST_EXEC)
	`ASSERT_NEXT(a_scan_end, (state_q == ST_SCAN) && stat.scan_last, state_q == ST_LAST)

endmodule

// ----- design/pts_dp.sv -----
`include "assert_macros.svh"

module pts_dp
	import pts_pkg::*;
#(
	parameter int MAX_TASKS = PTS_MAX_TASKS
) (
	input logic clk,
	input logic arst_n,
	input pts_ctrl_t ctrl,
	output pts_stat_t stat,
	input logic [PTS_CMD_W-1:0] s_tuser,
	input logic [PTS_IN_DATA_W-1:0] s_tdata,
	output logic m_tvalid,
	input logic m_tready,
	output logic [PTS_OUT_DATA_W-1:0] m_tdata
);

	localparam int SLOT_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int CNT_W = $clog2(MAX_TASKS + 1);

	logic [1:0] status_mem [MAX_TASKS];
	logic [7:0] prio_mem [MAX_TASKS];
	logic [31:0] wake_mem [MAX_TASKS];

	logic [2:0] cmd_q;
	logic [3:0] idx_q;
	logic [7:0] prio_q;
	logic [31:0] wake_q;

	logic [CNT_W-1:0] cnt_q;
	logic [SLOT_W-1:0] current_q;
	logic present_q;
	logic [31:0] tick_q;

	logic [SLOT_W-1:0] scan_q;
	logic valid_s1;
	logic cur_s1;
	logic [SLOT_W-1:0] scan_s1;
	logic [1:0] status_s1;
	logic [7:0] prio_s1;
	logic [31:0] wake_s1;

	logic [7:0] best_q;
	logic [SLOT_W-1:0] pick_q;
	logic found_q;
	logic cur_run_q;
	logic [3:0] added_q;
	logic err_q;

	logic m_tvalid_q;
	logic [PTS_OUT_DATA_W-1:0] m_tdata_q;

	logic full;
	logic idx_ok;
	logic [SLOT_W-1:0] rd_addr;
	logic st_we;
	logic [SLOT_W-1:0] st_wa;
	logic [1:0] st_wd;
	logic wake_due;
	logic better;

	assign full = (cnt_q >= CNT_W'(MAX_TASKS));
	assign idx_ok = ({{CNT_W{1'b0}}, idx_q} < {4'b0000, cnt_q});
	assign rd_addr = ctrl.cur_rd ? current_q : scan_q;
	assign wake_due = valid_s1 && (cmd_q == CMD_TICK) && (status_s1 == TS_SLEEPING)
		&& (tick_q >= wake_s1);
	assign better = valid_s1 && (cmd_q == CMD_SCHED) && (status_s1 == TS_READY)
		&& (prio_s1 >= best_q);

	always_comb begin
		st_we = 1'b0;
		st_wa = '0;
		st_wd = TS_READY;
		if (ctrl.exec) begin
			case (cmd_q)
				CMD_ADD: begin
					st_we = !full;
					st_wa = SLOT_W'(cnt_q);
					st_wd = TS_READY;
				end
				CMD_SLEEP: begin
					st_we = idx_ok;
					st_wa = SLOT_W'(idx_q);
					st_wd = TS_SLEEPING;
				end
				CMD_LAUNCH: begin
					st_we = (cnt_q != '0);
					st_wa = '0;
					st_wd = TS_RUNNING;
				end
				default: st_we = 1'b0;
			endcase
		end else if (wake_due) begin
			st_we = 1'b1;
			st_wa = scan_s1;
			st_wd = TS_READY;
		end else if (ctrl.demote) begin
			st_we = found_q && present_q && cur_run_q;
			st_wa = current_q;
			st_wd = TS_READY;
		end else if (ctrl.pick) begin
			st_we = found_q;
			st_wa = pick_q;
			st_wd = TS_RUNNING;
		end
	end

	always_ff @(posedge clk) begin
		if (st_we) begin
			status_mem[st_wa] <= st_wd;
		end
		status_s1 <= status_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (ctrl.exec && (cmd_q == CMD_ADD) && !full) begin
			prio_mem[SLOT_W'(cnt_q)] <= prio_q;
		end
		prio_s1 <= prio_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (ctrl.exec && (cmd_q == CMD_ADD) && !full) begin
			wake_mem[SLOT_W'(cnt_q)] <= '0;
		end else if (ctrl.exec && (cmd_q == CMD_SLEEP) && idx_ok) begin
			wake_mem[SLOT_W'(idx_q)] <= wake_q;
		end
		wake_s1 <= wake_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		scan_s1 <= scan_q;
		if (ctrl.cmd_load) begin
			cmd_q <= s_tuser;
			idx_q <= s_tdata[3:0];
			prio_q <= s_tdata[11:4];
			wake_q <= s_tdata[43:12];
			best_q <= '0;
			pick_q <= '0;
			scan_q <= '0;
			added_q <= '0;
			err_q <= 1'b0;
		end else begin
			if (ctrl.scan_rd) begin
				scan_q <= scan_q + SLOT_W'(1);
			end
			if (better) begin
				best_q <= prio_s1;
				pick_q <= scan_s1;
			end
			if (cur_s1) begin
				cur_run_q <= (status_s1 == TS_RUNNING);
			end
			if (ctrl.exec) begin
				case (cmd_q)
					CMD_ADD: begin
						added_q <= full ? 4'd0 : 4'(cnt_q);
						err_q <= full;
					end
					CMD_SLEEP: err_q <= !idx_ok;
					default: err_q <= 1'b0;
				endcase
			end
		end
		if (ctrl.out_load) begin
			m_tdata_q <= {4'b0000, tick_q, err_q, added_q, cmd_q == CMD_TICK, found_q,
				present_q, 4'(current_q)};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			current_q <= '0;
			present_q <= 1'b0;
			tick_q <= '0;
			valid_s1 <= 1'b0;
			cur_s1 <= 1'b0;
			found_q <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			valid_s1 <= ctrl.scan_rd;
			cur_s1 <= ctrl.cur_rd;
			if (ctrl.cmd_load) begin
				found_q <= 1'b0;
			end else if (better) begin
				found_q <= 1'b1;
			end
			if (ctrl.exec) begin
				case (cmd_q)
					CMD_TICK: tick_q <= tick_q + 32'd1;
					CMD_ADD: begin
						if (!full) begin
							cnt_q <= cnt_q + CNT_W'(1);
						end
					end
					CMD_LAUNCH: begin
						current_q <= '0;
						present_q <= (cnt_q != '0);
					end
					default: present_q <= present_q;
				endcase
			end
			if (ctrl.pick && found_q) begin
				current_q <= pick_q;
				present_q <= 1'b1;
			end
			if (ctrl.out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		stat.cmd = cmd_q;
		stat.cnt_zero = (cnt_q == '0);
		stat.scan_last = ((CNT_W'(scan_q) + CNT_W'(1)) == cnt_q);
		stat.out_free = !m_tvalid_q || m_tready;
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;

	`ASSERT_SAME(a_cnt_max, 1'b1, cnt_q <= CNT_W'(MAX_TASKS))
	`ASSERT_SAME(a_cur_filled, present_q, {1'b0, CNT_W'(current_q)} < {1'b0, cnt_q})

endmodule

// ----- design/priority_task_scheduler.sv -----
// Fixed-priority task scheduler with a table of up to MAX_TASKS tasks.
// Commands arrive as words on the s_ channel: tick, schedule, add task,
// sleep task and launch, with the command code in s_tuser. Each command
// yields exactly one status word on the m_ channel that reports the current
// task, the switch, schedule request, added slot and error flags, and the
// tick count after the command.
// Add, sleep, launch and unknown commands go from acceptance through the
// execute and output states to the result word. A tick and a schedule both
// walk the task table one slot per cycle through its single read port. With
// an empty table a tick or a schedule skips the walk and goes straight to
// the output state like the other commands.
// One command is worked on at a time; s_tready is high only while the block
// waits for a command. The result sits in an output register, so a stalled
// receiver holds the result word and the next command is still accepted;
// only that command's result waits until the register is free.
// Reset clears the task count, current task and tick counter at once; the
// task table itself needs no clearing, since only filled slots are read.
module priority_task_scheduler
	import pts_pkg::*;
#(
	parameter int MAX_TASKS = PTS_MAX_TASKS
) (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	// Fields from bit 0 up: task_index[3:0], new_priority[11:4],
	// wake_tick[43:12], zero fill.
	input logic [PTS_IN_DATA_W-1:0] s_tdata,
	// Fields from bit 0 up: cmd[2:0].
	input logic [PTS_CMD_W-1:0] s_tuser,
	output logic m_tvalid,
	input logic m_tready,
	// Fields from bit 0 up: running_task[3:0], running_valid[4], switched[5],
	// schedule_request[6], added_slot[10:7], error[11], tick_count[43:12],
	// zero fill.
	output logic [PTS_OUT_DATA_W-1:0] m_tdata
);

	pts_ctrl_t ctrl;
	pts_stat_t stat;

	pts_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.stat(stat),
		.ctrl(ctrl)
	);

	pts_dp #(
		.MAX_TASKS(MAX_TASKS)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.ctrl(ctrl),
		.stat(stat),
		.s_tuser(s_tuser),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

endmodule

// ----- dv/testbench.sv -----
import pts_pkg::*;

typedef struct packed {
	logic [3:0] fill;
	logic [31:0] wake;
	logic [7:0] prio;
	logic [3:0] slot;
} command_word_t;

typedef struct packed {
	logic [3:0] fill;
	logic [31:0] ticks;
	logic error;
	logic [3:0] added;
	logic request;
	logic switched;
	logic present;
	logic [3:0] running;
} status_word_t;

class scheduler_mirror;
	task_st_t status[PTS_MAX_TASKS];
	logic [7:0] prio[PTS_MAX_TASKS];
	logic [31:0] wake[PTS_MAX_TASKS];
	int unsigned task_total;
	logic [3:0] cur_slot;
	bit cur_present;
	logic [31:0] ticks;
	status_word_t expected_status[$];
	int failures;

	function new();
		for (int i = 0; i < PTS_MAX_TASKS; i++) begin
			status[i] = TS_READY;
			prio[i] = '0;
			wake[i] = '0;
		end
		task_total = 0;
		cur_slot = '0;
		cur_present = 1'b0;
		ticks = '0;
		failures = 0;
	endfunction

	function int pending();
		return expected_status.size();
	endfunction

	function void apply_command(logic [2:0] op, logic [3:0] slot, logic [7:0] new_prio,
			logic [31:0] new_wake);
		status_word_t w;
		logic [7:0] best;
		int pick;
		bit found;
		w = '0;
		best = '0;
		pick = 0;
		found = 1'b0;
		case (op)
			CMD_TICK: begin
				ticks = ticks + 32'd1;
				for (int i = 0; i < task_total; i++)
					if (status[i] == TS_SLEEPING && ticks >= wake[i])
						status[i] = TS_READY;
				w.request = 1'b1;
			end
			CMD_SCHED: begin
				for (int i = 0; i < task_total; i++) begin
					if (status[i] == TS_READY && prio[i] >= best) begin
						best = prio[i];
						pick = i;
						found = 1'b1;
					end
				end
				if (found) begin
					if (cur_present && status[cur_slot] == TS_RUNNING)
						status[cur_slot] = TS_READY;
					cur_slot = 4'(pick);
					cur_present = 1'b1;
					status[pick] = TS_RUNNING;
					w.switched = 1'b1;
				end
			end
			CMD_ADD: begin
				if (task_total < PTS_MAX_TASKS) begin
					status[task_total] = TS_READY;
					prio[task_total] = new_prio;
					wake[task_total] = '0;
					w.added = 4'(task_total);
					task_total++;
				end else begin
					w.error = 1'b1;
				end
			end
			CMD_SLEEP: begin
				if (slot < task_total) begin
					status[slot] = TS_SLEEPING;
					wake[slot] = new_wake;
				end else begin
					w.error = 1'b1;
				end
			end
			CMD_LAUNCH: begin
				cur_slot = '0;
				cur_present = (task_total > 0);
				if (task_total > 0)
					status[0] = TS_RUNNING;
			end
			default: begin
			end
		endcase
		w.running = cur_slot;
		w.present = cur_present;
		w.ticks = ticks;
		expected_status.push_back(w);
	endfunction

	function void report(string field, logic [31:0] want, logic [31:0] got);
		failures++;
		if (failures <= 10)
			$display("Mismatch in %s: expected %0h, got %0h", field, want, got);
	endfunction

	function void check_status(status_word_t got);
		status_word_t want;
		if (expected_status.size() == 0) begin
			failures++;
			if (failures <= 10)
				$display("Status word %0h arrived with no command pending", got);
			return;
		end
		want = expected_status.pop_front();
		if (got.running !== want.running)
			report("running_task", 32'(want.running), 32'(got.running));
		if (got.present !== want.present)
			report("running_valid", 32'(want.present), 32'(got.present));
		if (got.switched !== want.switched)
			report("switched", 32'(want.switched), 32'(got.switched));
		if (got.request !== want.request)
			report("schedule_request", 32'(want.request), 32'(got.request));
		if (got.added !== want.added)
			report("added_slot", 32'(want.added), 32'(got.added));
		if (got.error !== want.error)
			report("error", 32'(want.error), 32'(got.error));
		if (got.ticks !== want.ticks)
			report("tick_count", want.ticks, got.ticks);
	endfunction
endclass

module testbench;
	localparam int CYCLE_LIMIT = 300000;
	localparam logic [2:0] CMD_UNUSED_LO = 3'(CMD_LAUNCH + 3'd1);
	localparam logic [2:0] CMD_UNUSED_HI = '1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [PTS_IN_DATA_W-1:0] s_tdata = '0;
	logic [PTS_CMD_W-1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [PTS_OUT_DATA_W-1:0] m_tdata;

	int tx_idle_pct = 38;
	int rx_idle_pct = 62;
	scheduler_mirror mirror;

	priority_task_scheduler u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				mirror.check_status(status_word_t'(m_tdata));
			m_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	task automatic issue(input logic [2:0] op, input logic [3:0] slot,
			input logic [7:0] new_prio, input logic [31:0] new_wake);
		command_word_t w;
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		w = '0;
		w.slot = slot;
		w.prio = new_prio;
		w.wake = new_wake;
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= w;
		do @(posedge clk); while (!s_tready);
		mirror.apply_command(op, slot, new_prio, new_wake);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (mirror.pending() != 0);
	endtask

	task automatic issue_random();
		int r;
		logic [2:0] op;
		logic [3:0] slot;
		logic [31:0] new_wake;
		r = $urandom_range(99);
		slot = 4'($urandom_range(15, 0));
		new_wake = $urandom();
		if (r < 28) begin
			op = CMD_TICK;
		end else if (r < 52) begin
			op = CMD_SCHED;
		end else if (r < 62) begin
			op = CMD_ADD;
		end else if (r < 87) begin
			op = CMD_SLEEP;
			if (mirror.task_total > 0 && $urandom_range(9) < 8)
				slot = 4'($urandom_range(mirror.task_total - 1, 0));
			r = $urandom_range(9);
			if (r < 7)
				new_wake = mirror.ticks + $urandom_range(6, 0);
			else if (r == 7)
				new_wake = '0;
			else if (r == 8)
				new_wake = '1;
		end else if (r < 93) begin
			op = CMD_LAUNCH;
		end else begin
			op = 3'($urandom_range(CMD_UNUSED_HI, CMD_UNUSED_LO));
		end
		issue(op, slot, 8'($urandom_range(255, 0)), new_wake);
	endtask

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("Verification failed");
		$finish;
	end

	initial begin
		mirror = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty table: launch, schedule and sleep all find nothing.
		issue(CMD_LAUNCH, 4'd0, 8'd0, 32'd0);
		issue(CMD_SCHED, 4'd0, 8'd0, 32'd0);
		issue(CMD_SLEEP, 4'd0, 8'd0, 32'd5);
		issue(CMD_TICK, 4'd0, 8'd0, 32'd0);
		issue(CMD_UNUSED_LO, 4'd0, 8'd0, 32'd0);
		issue(CMD_UNUSED_HI, '1, '1, '1);
		issue(CMD_ADD, 4'd0, 8'd0, 32'd0);
		issue(CMD_ADD, 4'd0, 8'd255, 32'd0);
		issue(CMD_ADD, 4'd0, 8'd255, 32'd0);
		issue(CMD_SLEEP, 4'd15, 8'd0, 32'd0);
		issue(CMD_SLEEP, 4'd3, 8'd0, 32'd0);
		issue(CMD_LAUNCH, 4'd0, 8'd0, 32'd0);
		// A tie on the top priority goes to the later slot.
		issue(CMD_SCHED, 4'd0, 8'd0, 32'd0);
		issue(CMD_SLEEP, 4'd2, 8'd0, '1);
		issue(CMD_SCHED, 4'd0, 8'd0, 32'd0);
		issue(CMD_SLEEP, 4'd1, 8'd0, 32'd0);
		issue(CMD_SLEEP, 4'd0, 8'd0, mirror.ticks + 32'd2);
		issue(CMD_SCHED, 4'd0, 8'd0, 32'd0);
		issue(CMD_TICK, 4'd0, 8'd0, 32'd0);
		issue(CMD_TICK, 4'd0, 8'd0, 32'd0);
		issue(CMD_SCHED, 4'd0, 8'd0, 32'd0);
		issue(CMD_LAUNCH, 4'd0, 8'd0, 32'd0);
		issue(CMD_SCHED, 4'd0, 8'd0, 32'd0);

		for (int n = 0; n < 800; n++) begin
			if (n == 266) begin
				drain();
				tx_idle_pct = 62;
				rx_idle_pct = 38;
			end
			if (n == 533) begin
				drain();
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			issue_random();
		end
		drain();
		repeat (40) @(posedge clk);
		if (mirror.failures == 0 && mirror.pending() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
